/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ubxd_pkg.sv */
// Types and constants of the UBX deframer.
package ubxd_pkg;

  localparam logic [7:0]  SYNC_FIRST      = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND     = 8'h62;
  localparam logic [15:0] MAX_LEN_RESET   = 16'd1018;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_HEADER  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CK_A    = 3'd4,
    PH_CK_B    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_CLASS   = 2'd0,
    ROLE_ID      = 2'd1,
    ROLE_LENGTH  = 2'd2,
    ROLE_PAYLOAD = 2'd3
  } role_t;

  typedef enum logic [1:0] {
    ST_WITHIN   = 2'd0,
    ST_GOOD     = 2'd1,
    ST_BAD      = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  localparam logic [1:0] HC_CLASS = 2'd0;
  localparam logic [1:0] HC_ID    = 2'd1;
  localparam logic [1:0] HC_LEN_LO = 2'd2;
  localparam logic [1:0] HC_LEN_HI = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    role_t      role;
    status_t    status;
    logic       last;
  } res_t;

endpackage

/* hdl/ubxd_parser.sv */
// Frame parser state machine with running Fletcher sum.
module ubxd_parser import ubxd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [7:0]  byte_in,
  input  logic [15:0] max_len,
  output res_t        res
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  ck_a_r, ck_a_nxt;

  logic [7:0]  sum_a_add;
  logic [7:0]  sum_b_add;
  logic [15:0] len_full;
  logic [15:0] rem_dec;

  assign sum_a_add = sum_a_r + byte_in;
  assign sum_b_add = sum_b_r + sum_a_add;
  assign len_full  = {byte_in, len_r[7:0]};
  assign rem_dec   = (rem_r != 16'd0) ? rem_r - 16'd1 : 16'd0;

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    len_nxt     = len_r;
    rem_nxt     = rem_r;
    sum_a_nxt   = sum_a_r;
    sum_b_nxt   = sum_b_r;
    ck_a_nxt    = ck_a_r;
    res.valid   = 1'b0;
    res.data    = byte_in;
    res.role    = ROLE_CLASS;
    res.status  = ST_WITHIN;
    res.last    = 1'b0;
    unique case (phase_r)
      PH_SYNC2: begin
        if (byte_in == SYNC_SECOND) begin
          phase_nxt   = PH_HEADER;
          hdr_cnt_nxt = HC_CLASS;
          len_nxt     = 16'd0;
          sum_a_nxt   = 8'd0;
          sum_b_nxt   = 8'd0;
        end else if (byte_in != SYNC_FIRST) begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_HEADER: begin
        sum_a_nxt = sum_a_add;
        sum_b_nxt = sum_b_add;
        res.valid = 1'b1;
        case (hdr_cnt_r)
          HC_CLASS: begin
            res.role    = ROLE_CLASS;
            hdr_cnt_nxt = HC_ID;
          end
          HC_ID: begin
            res.role    = ROLE_ID;
            hdr_cnt_nxt = HC_LEN_LO;
          end
          HC_LEN_LO: begin
            res.role    = ROLE_LENGTH;
            len_nxt     = {8'd0, byte_in};
            hdr_cnt_nxt = HC_LEN_HI;
          end
          default: begin
            res.role    = ROLE_LENGTH;
            len_nxt     = len_full;
            hdr_cnt_nxt = HC_CLASS;
            if (len_full > max_len) begin
              phase_nxt  = PH_HUNT;
              res.status = ST_TOO_LONG;
              res.last   = 1'b1;
            end else begin
              rem_nxt   = len_full;
              phase_nxt = (len_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            end
          end
        endcase
      end
      PH_PAYLOAD: begin
        sum_a_nxt = sum_a_add;
        sum_b_nxt = sum_b_add;
        rem_nxt   = rem_dec;
        if (rem_dec == 16'd0) phase_nxt = PH_CK_A;
        res.valid = 1'b1;
        res.role  = ROLE_PAYLOAD;
      end
      PH_CK_A: begin
        ck_a_nxt  = byte_in;
        phase_nxt = PH_CK_B;
      end
      PH_CK_B: begin
        phase_nxt  = PH_HUNT;
        res.valid  = 1'b1;
        res.data   = 8'd0;
        res.last   = 1'b1;
        res.status = ((ck_a_r == sum_a_r) && (byte_in == sum_b_r)) ? ST_GOOD : ST_BAD;
      end
      default: begin
        // hunting, and any unused phase code
        phase_nxt = (byte_in == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      hdr_cnt_r <= HC_CLASS;
      len_r     <= 16'd0;
      rem_r     <= 16'd0;
      sum_a_r   <= 8'd0;
      sum_b_r   <= 8'd0;
      ck_a_r    <= 8'd0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      len_r     <= len_nxt;
      rem_r     <= rem_nxt;
      sum_a_r   <= sum_a_nxt;
      sum_b_r   <= sum_b_nxt;
      ck_a_r    <= ck_a_nxt;
    end
  end

endmodule

/* hdl/ubx_frame_deframer_core.sv */
// UBX frame deframer top level: input register, parser, result register.
//
// Input channel: in_valid / in_stall / in_byte carries one raw serial byte per
//   request. A request is taken at a rising edge with in_valid high and
//   in_stall low.
// Result channel: out_valid / out_stall with out_byte, out_byte_role,
//   out_frame_status and out_frame_last. Sync bytes, bytes dropped while hunting
//   and the first check byte make no result; every other byte makes exactly one.
// Config: cfg_wr_en / cfg_wr_data write the payload length limit
//   (reset 1018). Write it only while no request is in flight.
// Timing: a byte taken into the input register is parsed from there, and
//   its result is captured in the result register that drives the ports.
// Throughput: one byte per cycle while no result is stalled, set by the single
//   parse stage; checksum and length logic sits between input and result regs.
// Stall: while the result register holds a stalled request the parser
//   holds and in_stall rises once the input register is also full; no
//   request is lost or repeated.
// Reset (rst_n, synchronous, active low): both registers empty, parser
//   hunting for the first sync byte, limit back to 1018.
module ubx_frame_deframer_core import ubxd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_byte_role,
  output logic [1:0]  out_frame_status,
  output logic        out_frame_last,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic [15:0] max_len_r;
  logic        advance;
  res_t        res;
  res_t        out_r;

  // parse when a byte waits and the result slot is free or draining
  assign advance  = in_valid_r && (!out_r.valid || !out_stall);
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) in_byte_r <= in_byte;
  end

  ubxd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .byte_in (in_byte_r),
    .max_len (max_len_r),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (advance) begin
      out_r <= res;
    end else if (!out_stall) begin
      out_r.valid <= 1'b0;
    end
  end

  assign out_valid        = out_r.valid;
  assign out_byte         = out_r.data;
  assign out_byte_role    = out_r.role;
  assign out_frame_status = out_r.status;
  assign out_frame_last   = out_r.last;

endmodule

/* hdl/ubxd_checker.sv */
// Port-level checker for the UBX deframer, bound to the top level.
`include "assert_macros.svh"

module ubxd_checker import ubxd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic [1:0]  out_byte_role,
  input logic [1:0]  out_frame_status,
  input logic        out_frame_last
);

  // a frame ends exactly when its status is not "within"
  `ASSERT_IMPLY(a_last_status, clk, rst_n, out_valid,
    (out_frame_status == ST_WITHIN) == !out_frame_last, "last/status mismatch")

  // checksum verdicts carry a zero byte in the class role
  `ASSERT_IMPLY(a_end_fields, clk, rst_n,
    out_valid && (out_frame_status == ST_GOOD || out_frame_status == ST_BAD),
    out_byte == 8'd0 && out_byte_role == ROLE_CLASS, "bad end result fields")

  // oversize abort only on a length byte
  `ASSERT_IMPLY(a_too_long_role, clk, rst_n,
    out_valid && out_frame_status == ST_TOO_LONG,
    out_byte_role == ROLE_LENGTH, "oversize abort not on length byte")

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_byte) && $stable(out_frame_status), "stalled result changed")

  // input only backs up behind a stalled result
  `ASSERT_IMPLY(a_in_stall_cause, clk, rst_n, in_stall,
    out_valid && out_stall, "input stalled while result side free")

endmodule

bind ubx_frame_deframer_core ubxd_checker u_ubxd_checker (.*);
